FILE: rtl/point_segment_distance_2d_defines.svh
// Assertion macros shared by the point to segment distance RTL.
`ifndef POINT_SEGMENT_DISTANCE_2D_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_2D_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define PSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/psd_pkg.sv
// Types and constants of the point to segment distance pipeline.
`default_nettype none
package psd_pkg;

	localparam int COORD_WIDTH    = 16;
	localparam int QUOT_FRAC_BITS = 16;

	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int DOT_W   = PROD_W + 1;
	localparam int DIV_W   = DOT_W - 1;
	localparam int OFFP_W  = QUOT_FRAC_BITS + DIFF_W;
	localparam int DSQ_W   = PROD_W;
	localparam int ROOT_W  = DSQ_W / 2;
	localparam int SQREM_W = ROOT_W + 3;

	typedef enum logic [1:0] {
		CASE_START    = 2'd0,
		CASE_END      = 2'd1,
		CASE_INTERIOR = 2'd2
	} case_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] start_z;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
		logic signed [COORD_WIDTH-1:0] end_z;
		logic signed [COORD_WIDTH-1:0] query_x;
		logic signed [COORD_WIDTH-1:0] query_y;
	} in_word_t;

	typedef struct packed {
		logic        [ROOT_W-1:0]      distance;
		logic signed [COORD_WIDTH-1:0] closest_x;
		logic signed [COORD_WIDTH-1:0] closest_y;
		logic signed [COORD_WIDTH-1:0] closest_z;
		case_t                         closest_case;
	} out_word_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] closest_x;
		logic signed [COORD_WIDTH-1:0] closest_y;
		logic signed [COORD_WIDTH-1:0] closest_z;
		case_t                         closest_case;
	} tail_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] sx;
		logic signed [COORD_WIDTH-1:0] sy;
		logic signed [COORD_WIDTH-1:0] sz;
		logic signed [COORD_WIDTH-1:0] ex;
		logic signed [COORD_WIDTH-1:0] ey;
		logic signed [COORD_WIDTH-1:0] ez;
		logic signed [COORD_WIDTH-1:0] qx;
		logic signed [COORD_WIDTH-1:0] qy;
		logic signed [DIFF_W-1:0]      vx;
		logic signed [DIFF_W-1:0]      vy;
		case_t                         kind;
	} mid_t;

endpackage
`default_nettype wire

FILE: rtl/psd_isqrt.sv
// Pipelined floor square root, one result bit per stage, with sideband.
`default_nettype none
module psd_isqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      src_valid,
	input  wire logic [psd_pkg::DSQ_W-1:0] src_dsq,
	input  wire psd_pkg::tail_t            src_tail,
	output logic                           result_valid,
	output psd_pkg::out_word_t             result
);
	import psd_pkg::*;
	`include "point_segment_distance_2d_defines.svh"

	logic                vld_sq  [ROOT_W];
	logic [SQREM_W-1:0]  rem_sq  [ROOT_W];
	logic [ROOT_W-1:0]   root_sq [ROOT_W];
	logic [DSQ_W-1:0]    n_sq    [ROOT_W];
	tail_t               tail_sq [ROOT_W];

	logic [SQREM_W-1:0]  rem_d  [ROOT_W];
	logic [ROOT_W-1:0]   root_d [ROOT_W];
	logic [DSQ_W-1:0]    n_d    [ROOT_W];

	always_comb begin
		logic [SQREM_W-1:0] rp;
		logic [ROOT_W-1:0]  op;
		logic [DSQ_W-1:0]   np;
		logic [SQREM_W-1:0] rt;
		logic [SQREM_W-1:0] tr;
		for (int i = 0; i < ROOT_W; i++) begin
			if (i == 0) begin
				rp = '0;
				op = '0;
				np = src_dsq;
			end else begin
				rp = rem_sq[(i == 0) ? 0 : i - 1];
				op = root_sq[(i == 0) ? 0 : i - 1];
				np = n_sq[(i == 0) ? 0 : i - 1];
			end
			rt = {rp[SQREM_W-3:0], np[DSQ_W-1 -: 2]};
			tr = SQREM_W'({op, 2'b01});
			if (rt >= tr) begin
				rem_d[i]  = rt - tr;
				root_d[i] = {op[ROOT_W-2:0], 1'b1};
			end else begin
				rem_d[i]  = rt;
				root_d[i] = {op[ROOT_W-2:0], 1'b0};
			end
			n_d[i] = {np[DSQ_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROOT_W; i++)
				vld_sq[i] <= 1'b0;
		end else if (en) begin
			vld_sq[0] <= src_valid;
			for (int i = 1; i < ROOT_W; i++)
				vld_sq[i] <= vld_sq[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < ROOT_W; i++) begin
				rem_sq[i]  <= rem_d[i];
				root_sq[i] <= root_d[i];
				n_sq[i]    <= n_d[i];
			end
			tail_sq[0] <= src_tail;
			for (int i = 1; i < ROOT_W; i++)
				tail_sq[i] <= tail_sq[i-1];
		end
	end

	assign result_valid          = vld_sq[ROOT_W-1];
	assign result.distance       = root_sq[ROOT_W-1];
	assign result.closest_x      = tail_sq[ROOT_W-1].closest_x;
	assign result.closest_y      = tail_sq[ROOT_W-1].closest_y;
	assign result.closest_z      = tail_sq[ROOT_W-1].closest_z;
	assign result.closest_case   = tail_sq[ROOT_W-1].closest_case;

	`PSD_ASSERT_NEXT(a_hold_root, !en, $stable(root_sq[ROOT_W-1]), "Root changed while stalled.")
	`PSD_ASSERT_NEXT(a_hold_vld, !en, $stable(vld_sq[ROOT_W-1]), "Valid changed while stalled.")
	`PSD_ASSERT_NEXT(a_enter, en && src_valid, vld_sq[0], "Word lost at root entry.")

endmodule
`default_nettype wire

FILE: rtl/point_segment_distance_2d.sv
// Top level: xy distance from a point to a segment, and the closest point.
//
//   channel   signals                          word
//   query     query_valid / query_ready        psd_pkg::in_word_t
//   result    result_valid / result_ready      psd_pkg::out_word_t
//
// One word is taken every cycle while the result is not stalled; the divider forms
// one quotient bit and the square root one root bit per stage.
// The whole pipeline advances together; a stalled result holds every stage.
// Reset clears the stage valid bits only.
`default_nettype none
module point_segment_distance_2d (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               query_valid,
	output logic                    query_ready,
	input  wire psd_pkg::in_word_t  query,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output psd_pkg::out_word_t      result
);
	import psd_pkg::*;
	`include "point_segment_distance_2d_defines.svh"

	logic en;
	assign en          = !result_valid || result_ready;
	assign query_ready = en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	mid_t m_s1, m_s2, m_s3, m_s4;
	logic signed [DIFF_W-1:0] wx_s1, wy_s1;
	logic signed [PROD_W-1:0] pwx_s2, pwy_s2, pvx_s2, pvy_s2;
	logic [DIV_W-1:0]         rem_s3, c2_s3;
	logic [OFFP_W-1:0]        px_s4, py_s4;
	tail_t                    t_s5, t_s6, t_s7;
	logic signed [DIFF_W-1:0] dx_s5, dy_s5;
	logic signed [PROD_W-1:0] sx_s6, sy_s6;
	logic [DSQ_W-1:0]         dsq_s7;

	logic                      div_vld_sd  [QUOT_FRAC_BITS];
	logic [DIV_W-1:0]          div_rem_sd  [QUOT_FRAC_BITS];
	logic [DIV_W-1:0]          div_c2_sd   [QUOT_FRAC_BITS];
	logic [QUOT_FRAC_BITS-1:0] div_q_sd    [QUOT_FRAC_BITS];
	mid_t                      div_m_sd    [QUOT_FRAC_BITS];

	logic [DIV_W-1:0]          rem_d [QUOT_FRAC_BITS];
	logic [QUOT_FRAC_BITS-1:0] q_d   [QUOT_FRAC_BITS];

	mid_t                       s1_d;
	mid_t                       m3_d;
	logic signed [DOT_W-1:0]    c1_w, c2_w;
	case_t                      kind_w;
	mid_t                       ml;
	logic [DIFF_W-1:0]          magx_w, magy_w;
	logic signed [COORD_WIDTH+1:0] cxf_w, cyf_w;
	tail_t                      t5_d;

	always_comb begin
		s1_d      = '0;
		s1_d.sx   = query.start_x;
		s1_d.sy   = query.start_y;
		s1_d.sz   = query.start_z;
		s1_d.ex   = query.end_x;
		s1_d.ey   = query.end_y;
		s1_d.ez   = query.end_z;
		s1_d.qx   = query.query_x;
		s1_d.qy   = query.query_y;
		s1_d.vx   = DIFF_W'(query.end_x) - DIFF_W'(query.start_x);
		s1_d.vy   = DIFF_W'(query.end_y) - DIFF_W'(query.start_y);
		s1_d.kind = CASE_START;
	end

	always_comb begin
		c1_w = DOT_W'(pwx_s2) + DOT_W'(pwy_s2);
		c2_w = DOT_W'(pvx_s2) + DOT_W'(pvy_s2);
		if (c1_w <= 0)
			kind_w = CASE_START;
		else if (c2_w <= c1_w)
			kind_w = CASE_END;
		else
			kind_w = CASE_INTERIOR;
		m3_d      = m_s2;
		m3_d.kind = kind_w;
	end

	// Restoring division of c1 by c2, one fraction bit per stage.
	always_comb begin
		logic [DIV_W-1:0]          rp;
		logic [DIV_W-1:0]          cp;
		logic [QUOT_FRAC_BITS-1:0] qp;
		logic [DIV_W:0]            twice;
		for (int i = 0; i < QUOT_FRAC_BITS; i++) begin
			if (i == 0) begin
				rp = rem_s3;
				cp = c2_s3;
				qp = '0;
			end else begin
				rp = div_rem_sd[(i == 0) ? 0 : i - 1];
				cp = div_c2_sd[(i == 0) ? 0 : i - 1];
				qp = div_q_sd[(i == 0) ? 0 : i - 1];
			end
			twice = {rp, 1'b0};
			if (twice >= {1'b0, cp}) begin
				rem_d[i] = DIV_W'(twice - {1'b0, cp});
				q_d[i]   = {qp[QUOT_FRAC_BITS-2:0], 1'b1};
			end else begin
				rem_d[i] = twice[DIV_W-1:0];
				q_d[i]   = {qp[QUOT_FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		ml     = div_m_sd[QUOT_FRAC_BITS-1];
		magx_w = ml.vx[DIFF_W-1] ? DIFF_W'(-ml.vx) : DIFF_W'(ml.vx);
		magy_w = ml.vy[DIFF_W-1] ? DIFF_W'(-ml.vy) : DIFF_W'(ml.vy);
	end

	always_comb begin
		logic signed [COORD_WIDTH+1:0] ox;
		logic signed [COORD_WIDTH+1:0] oy;
		ox = $signed({1'b0, px_s4[QUOT_FRAC_BITS +: DIFF_W]});
		oy = $signed({1'b0, py_s4[QUOT_FRAC_BITS +: DIFF_W]});
		cxf_w = (COORD_WIDTH+2)'(m_s4.sx) + (m_s4.vx[DIFF_W-1] ? -ox : ox);
		cyf_w = (COORD_WIDTH+2)'(m_s4.sy) + (m_s4.vy[DIFF_W-1] ? -oy : oy);
		t5_d.closest_case = m_s4.kind;
		case (m_s4.kind)
			CASE_END: begin
				t5_d.closest_x = m_s4.ex;
				t5_d.closest_y = m_s4.ey;
				t5_d.closest_z = m_s4.ez;
			end
			CASE_INTERIOR: begin
				t5_d.closest_x = cxf_w[COORD_WIDTH-1:0];
				t5_d.closest_y = cyf_w[COORD_WIDTH-1:0];
				t5_d.closest_z = m_s4.sz;
			end
			default: begin
				t5_d.closest_x = m_s4.sx;
				t5_d.closest_y = m_s4.sy;
				t5_d.closest_z = m_s4.sz;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int i = 0; i < QUOT_FRAC_BITS; i++)
				div_vld_sd[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= query_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			div_vld_sd[0] <= v_s3;
			for (int i = 1; i < QUOT_FRAC_BITS; i++)
				div_vld_sd[i] <= div_vld_sd[i-1];
			v_s4 <= div_vld_sd[QUOT_FRAC_BITS-1];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1  <= s1_d;
			wx_s1 <= DIFF_W'(query.query_x) - DIFF_W'(query.start_x);
			wy_s1 <= DIFF_W'(query.query_y) - DIFF_W'(query.start_y);

			m_s2   <= m_s1;
			pwx_s2 <= wx_s1 * m_s1.vx;
			pwy_s2 <= wy_s1 * m_s1.vy;
			pvx_s2 <= m_s1.vx * m_s1.vx;
			pvy_s2 <= m_s1.vy * m_s1.vy;

			m_s3      <= m3_d;
			rem_s3    <= (kind_w == CASE_INTERIOR) ? c1_w[DIV_W-1:0] : '0;
			c2_s3     <= c2_w[DIV_W-1:0];

			div_m_sd[0]  <= m_s3;
			div_c2_sd[0] <= c2_s3;
			for (int i = 1; i < QUOT_FRAC_BITS; i++) begin
				div_m_sd[i]  <= div_m_sd[i-1];
				div_c2_sd[i] <= div_c2_sd[i-1];
			end
			for (int i = 0; i < QUOT_FRAC_BITS; i++) begin
				div_rem_sd[i] <= rem_d[i];
				div_q_sd[i]   <= q_d[i];
			end

			m_s4  <= ml;
			px_s4 <= OFFP_W'(div_q_sd[QUOT_FRAC_BITS-1]) * OFFP_W'(magx_w);
			py_s4 <= OFFP_W'(div_q_sd[QUOT_FRAC_BITS-1]) * OFFP_W'(magy_w);

			t_s5  <= t5_d;
			dx_s5 <= DIFF_W'(m_s4.qx) - DIFF_W'(t5_d.closest_x);
			dy_s5 <= DIFF_W'(m_s4.qy) - DIFF_W'(t5_d.closest_y);

			t_s6  <= t_s5;
			sx_s6 <= dx_s5 * dx_s5;
			sy_s6 <= dy_s5 * dy_s5;

			t_s7   <= t_s6;
			dsq_s7 <= DSQ_W'(sx_s6) + DSQ_W'(sy_s6);
		end
	end

	psd_isqrt u_isqrt (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.src_valid    (v_s7),
		.src_dsq      (dsq_s7),
		.src_tail     (t_s7),
		.result_valid (result_valid),
		.result       (result)
	);

	`PSD_ASSERT(a_ready, query_ready == (!result_valid || result_ready), "Ready out of step with output.")
	`PSD_ASSERT_NEXT(a_take, query_valid && query_ready, v_s1, "Accepted word lost at entry.")
	`PSD_ASSERT_NEXT(a_stall, !en, $stable(v_s3) && $stable(v_s7), "Pipeline moved while stalled.")

endmodule
`default_nettype wire
